// ===== sv/trirast_pkg.sv =====
// Shared constants, codes and types of the triangle scan-line rasterizer.
package trirast_pkg;

   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 16;
   localparam int LEN_BITS   = 12;
   localparam int SPAN_BITS  = 11;
   localparam int MAX_BUFFER = 2048;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int NUM_EDGES  = 3;
   localparam int CNT_BITS   = 2;
   localparam int NUM_REGS   = 8;
   localparam int REG_BITS   = $clog2(NUM_REGS);
   localparam int ADDR_BITS  = REG_BITS + 2;
   localparam int DATA_BITS  = 32;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COLOR_BITS-1:0] color_type;
   typedef logic        [LEN_BITS-1:0]   len_type;
   typedef logic        [SPAN_BITS-1:0]  span_type;

   localparam len_type MAX_LEN = len_type'(MAX_BUFFER);

   typedef enum logic [REG_BITS-1:0] {
      REG_VERTEX_A_X,
      REG_VERTEX_A_Y,
      REG_VERTEX_B_X,
      REG_VERTEX_B_Y,
      REG_VERTEX_C_X,
      REG_VERTEX_C_Y,
      REG_DRAW_COLOR,
      REG_FILL_MODE
   } reg_idx_type;

   typedef enum logic [1:0] {
      EDGE_AB,
      EDGE_AC,
      EDGE_BC
   } edge_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      coord_type va_x;
      coord_type va_y;
      coord_type vb_x;
      coord_type vb_y;
      coord_type vc_x;
      coord_type vc_y;
      color_type color;
      logic      fill;
   } cfg_type;

   typedef struct packed {
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      coord_type line;
      coord_type wx;
      len_type   n;
   } walk_cmd_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      logic     any;
      span_type lo;
      span_type hi;
   } walk_res_type;

endpackage

// ===== sv/trirast_ifs.sv =====
// Valid/ready channel interfaces for scan-line requests and span results.
interface trirast_req_if;
   import trirast_pkg::*;

   logic      valid;
   logic      ready;
   coord_type scan_line;
   coord_type window_start_x;
   len_type   buffer_length;

   modport source (output valid, output scan_line, output window_start_x,
                   output buffer_length, input ready);
   modport sink (input valid, input scan_line, input window_start_x,
                 input buffer_length, output ready);
endinterface

interface trirast_rsp_if;
   import trirast_pkg::*;

   logic      valid;
   logic      ready;
   logic      span_valid;
   span_type  span_low;
   span_type  span_high;
   color_type pixel_color;
   logic      last_result;

   modport source (output valid, output span_valid, output span_low, output span_high,
                   output pixel_color, output last_result, input ready);
   modport sink (input valid, input span_valid, input span_low, input span_high,
                 input pixel_color, input last_result, output ready);
endinterface

// ===== sv/trirast_csr.sv =====
// APB-style configuration register file: vertices, color and fill mode.
module trirast_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [trirast_pkg::ADDR_BITS-1:0]    csr_paddr,
   input  logic [trirast_pkg::DATA_BITS-1:0]    csr_pwdata,
   output logic [trirast_pkg::DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output trirast_pkg::cfg_type                 cfg
);
   import trirast_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;
   coord_type   wr_coord;

   assign idx        = reg_idx_type'(csr_paddr[ADDR_BITS-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_coord   = coord_type'(csr_pwdata[COORD_BITS-1:0]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_VERTEX_A_X: cfg_in.va_x  = wr_coord;
            REG_VERTEX_A_Y: cfg_in.va_y  = wr_coord;
            REG_VERTEX_B_X: cfg_in.vb_x  = wr_coord;
            REG_VERTEX_B_Y: cfg_in.vb_y  = wr_coord;
            REG_VERTEX_C_X: cfg_in.vc_x  = wr_coord;
            REG_VERTEX_C_Y: cfg_in.vc_y  = wr_coord;
            REG_DRAW_COLOR: cfg_in.color = csr_pwdata[COLOR_BITS-1:0];
            REG_FILL_MODE:  cfg_in.fill  = csr_pwdata[0];
            default:        cfg_in       = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_VERTEX_A_X: csr_prdata = DATA_BITS'($unsigned(cfg_ff.va_x));
         REG_VERTEX_A_Y: csr_prdata = DATA_BITS'($unsigned(cfg_ff.va_y));
         REG_VERTEX_B_X: csr_prdata = DATA_BITS'($unsigned(cfg_ff.vb_x));
         REG_VERTEX_B_Y: csr_prdata = DATA_BITS'($unsigned(cfg_ff.vb_y));
         REG_VERTEX_C_X: csr_prdata = DATA_BITS'($unsigned(cfg_ff.vc_x));
         REG_VERTEX_C_Y: csr_prdata = DATA_BITS'($unsigned(cfg_ff.vc_y));
         REG_DRAW_COLOR: csr_prdata = DATA_BITS'(cfg_ff.color);
         REG_FILL_MODE:  csr_prdata = DATA_BITS'(cfg_ff.fill);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/trirast_edge_walk.sv =====
// Bresenham edge stepper: one step per cycle, collects the clipped run on the scan line.
module trirast_edge_walk (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  trirast_pkg::walk_cmd_type cmd,
   output trirast_pkg::walk_res_type res
);
   import trirast_pkg::*;

   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic signed [ERR_BITS:0]     dbl_type;

   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   logic      any_ff, any_in;
   span_type  lo_ff, lo_in;
   span_type  hi_ff, hi_in;
   coord_type x_ff, x_in;
   coord_type y_ff, y_in;
   coord_type xe_ff, xe_in;
   coord_type ye_ff, ye_in;
   coord_type line_ff, line_in;
   coord_type wx_ff, wx_in;
   len_type   n_ff, n_in;
   delta_type dx_ff, dx_in;
   delta_type dy_ff, dy_in;
   err_type   err_ff, err_in;
   logic      sx_neg_ff, sx_neg_in;
   logic      sy_neg_ff, sy_neg_in;

   // setup
   delta_type dxs, dys, setup_dx, setup_dy;
   logic      spans;
   // step
   dbl_type   e2;
   logic      x_step, y_step;
   err_type   dx_term, dy_term;
   delta_type r;
   span_type  r_idx;
   logic      on_line, in_buf, hit, at_end, finish;

   assign dxs      = DELTA_BITS'(cmd.xe) - DELTA_BITS'(cmd.xs);
   assign dys      = DELTA_BITS'(cmd.ye) - DELTA_BITS'(cmd.ys);
   assign setup_dx = dxs[DELTA_BITS-1] ? -dxs : dxs;
   assign setup_dy = dys[DELTA_BITS-1] ? -dys : dys;
   assign spans    = (cmd.line >= cmd.ys && cmd.line <= cmd.ye) ||
                     (cmd.line >= cmd.ye && cmd.line <= cmd.ys);

   assign e2      = signed'({err_ff, 1'b0});
   assign x_step  = e2 > -(ERR_BITS+1)'(dy_ff);
   assign y_step  = e2 < (ERR_BITS+1)'(dx_ff);
   assign dx_term = y_step ? ERR_BITS'(dx_ff) : err_type'(0);
   assign dy_term = x_step ? ERR_BITS'(dy_ff) : err_type'(0);

   assign r       = DELTA_BITS'(x_ff) - DELTA_BITS'(wx_ff);
   assign r_idx   = r[SPAN_BITS-1:0];
   assign on_line = (y_ff == line_ff);
   assign in_buf  = !r[DELTA_BITS-1] && ($unsigned(r) < DELTA_BITS'(n_ff));
   assign hit     = on_line && in_buf;
   assign at_end  = (x_ff == xe_ff) && (y_ff == ye_ff);
   // leaving the scan line ends the run, y only moves toward the end vertex
   assign finish  = at_end || (on_line && y_step);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      any_in    = any_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      xe_in     = xe_ff;
      ye_in     = ye_ff;
      line_in   = line_ff;
      wx_in     = wx_ff;
      n_in      = n_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      err_in    = err_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      if (start) begin
         busy_in   = spans;
         done_in   = !spans;
         any_in    = 1'b0;
         x_in      = cmd.xs;
         y_in      = cmd.ys;
         xe_in     = cmd.xe;
         ye_in     = cmd.ye;
         line_in   = cmd.line;
         wx_in     = cmd.wx;
         n_in      = cmd.n;
         dx_in     = setup_dx;
         dy_in     = setup_dy;
         err_in    = ERR_BITS'(setup_dx) - ERR_BITS'(setup_dy);
         sx_neg_in = !(cmd.xs < cmd.xe);
         sy_neg_in = !(cmd.ys < cmd.ye);
      end else if (busy_ff) begin
         if (hit) begin
            any_in = 1'b1;
            lo_in  = (!any_ff || r_idx < lo_ff) ? r_idx : lo_ff;
            hi_in  = (!any_ff || r_idx > hi_ff) ? r_idx : hi_ff;
         end
         if (finish) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            err_in = err_ff - dy_term + dx_term;
            if (x_step) begin
               x_in = sx_neg_ff ? x_ff - COORD_BITS'(1) : x_ff + COORD_BITS'(1);
            end
            if (y_step) begin
               y_in = sy_neg_ff ? y_ff - COORD_BITS'(1) : y_ff + COORD_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         any_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         any_ff  <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      xe_ff     <= xe_in;
      ye_ff     <= ye_in;
      line_ff   <= line_in;
      wx_ff     <= wx_in;
      n_ff      <= n_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      err_ff    <= err_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
   end

   assign res = '{busy: busy_ff, done: done_ff, any: any_ff, lo: lo_ff, hi: hi_ff};

endmodule

// ===== sv/triangle_scanline_rasterizer_core.sv =====
// Sequence: per edge, the walker is launched and takes Bresenham steps from its first vertex
// to the end of its run on the scan line; edges not crossing the line end without stepping.
// Then the 1 to 3 results are sent one at a time, as the sink takes them.
// Throughput: one scan line at a time, set by the single edge stepping unit.
// Reset: synchronous, active high; clears control state and all configuration to 0.
module triangle_scanline_rasterizer_core (
   input  logic                              clock,
   input  logic                              reset,
   trirast_req_if.sink                       req_if,
   trirast_rsp_if.source                     rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [trirast_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [trirast_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [trirast_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import trirast_pkg::*;

   cfg_type      cfg;
   walk_cmd_type walk_cmd;
   walk_res_type walk_res;
   logic         walk_start;

   state_type             state_ff, state_in;
   edge_type              edge_ff, edge_in;
   coord_type             line_ff, line_in;
   coord_type             wx_ff, wx_in;
   len_type               n_ff, n_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]   emit_ff, emit_in;
   span_type              slot_lo_ff [NUM_EDGES];
   span_type              slot_lo_in [NUM_EDGES];
   span_type              slot_hi_ff [NUM_EDGES];
   span_type              slot_hi_in [NUM_EDGES];

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_span_valid_ff, rsp_span_valid_in;
   span_type  rsp_lo_ff, rsp_lo_in;
   span_type  rsp_hi_ff, rsp_hi_in;
   color_type rsp_color_ff, rsp_color_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      emit_last;

   trirast_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trirast_edge_walk u_walk (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .cmd   (walk_cmd),
      .res   (walk_res)
   );

   assign req_if.ready = (state_ff == ST_IDLE);

   // edge endpoints, each walked from its first named vertex
   always_comb begin
      walk_cmd.line = line_ff;
      walk_cmd.wx   = wx_ff;
      walk_cmd.n    = n_ff;
      unique case (edge_ff)
         EDGE_AB: begin
            walk_cmd.xs = cfg.va_x;
            walk_cmd.ys = cfg.va_y;
            walk_cmd.xe = cfg.vb_x;
            walk_cmd.ye = cfg.vb_y;
         end
         EDGE_AC: begin
            walk_cmd.xs = cfg.va_x;
            walk_cmd.ys = cfg.va_y;
            walk_cmd.xe = cfg.vc_x;
            walk_cmd.ye = cfg.vc_y;
         end
         default: begin
            walk_cmd.xs = cfg.vb_x;
            walk_cmd.ys = cfg.vb_y;
            walk_cmd.xe = cfg.vc_x;
            walk_cmd.ye = cfg.vc_y;
         end
      endcase
   end

   assign emit_last = (emit_ff == cnt_ff - CNT_BITS'(1));

   always_comb begin
      state_in          = state_ff;
      edge_in           = edge_ff;
      line_in           = line_ff;
      wx_in             = wx_ff;
      n_in              = n_ff;
      cnt_in            = cnt_ff;
      emit_in           = emit_ff;
      slot_lo_in        = slot_lo_ff;
      slot_hi_in        = slot_hi_ff;
      walk_start        = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_if.ready;
      rsp_span_valid_in = rsp_span_valid_ff;
      rsp_lo_in         = rsp_lo_ff;
      rsp_hi_in         = rsp_hi_ff;
      rsp_color_in      = rsp_color_ff;
      rsp_last_in       = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               line_in  = req_if.scan_line;
               wx_in    = req_if.window_start_x;
               n_in     = (req_if.buffer_length > MAX_LEN) ? MAX_LEN : req_if.buffer_length;
               cnt_in   = '0;
               edge_in  = EDGE_AB;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            walk_start = 1'b1;
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            if (walk_res.done) begin
               if (walk_res.any) begin
                  if (cfg.fill) begin
                     // fill keeps one running min/max span in slot zero
                     if (cnt_ff == '0) begin
                        slot_lo_in[0] = walk_res.lo;
                        slot_hi_in[0] = walk_res.hi;
                     end else begin
                        if (walk_res.lo < slot_lo_ff[0]) slot_lo_in[0] = walk_res.lo;
                        if (walk_res.hi > slot_hi_ff[0]) slot_hi_in[0] = walk_res.hi;
                     end
                     cnt_in = CNT_BITS'(1);
                  end else begin
                     slot_lo_in[cnt_ff] = walk_res.lo;
                     slot_hi_in[cnt_ff] = walk_res.hi;
                     cnt_in             = cnt_ff + CNT_BITS'(1);
                  end
               end
               unique case (edge_ff)
                  EDGE_AB: begin
                     edge_in  = EDGE_AC;
                     state_in = ST_LAUNCH;
                  end
                  EDGE_AC: begin
                     edge_in  = EDGE_BC;
                     state_in = ST_LAUNCH;
                  end
                  default: begin
                     emit_in  = '0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_span_valid_in = 1'b0;
                  rsp_lo_in         = '0;
                  rsp_hi_in         = '0;
                  rsp_color_in      = '0;
                  rsp_last_in       = 1'b1;
                  state_in          = ST_IDLE;
               end else begin
                  rsp_span_valid_in = 1'b1;
                  rsp_lo_in         = slot_lo_ff[emit_ff];
                  rsp_hi_in         = slot_hi_ff[emit_ff];
                  rsp_color_in      = cfg.color;
                  rsp_last_in       = emit_last;
                  emit_in           = emit_ff + CNT_BITS'(1);
                  if (emit_last) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edge_ff      <= EDGE_AB;
         cnt_ff       <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_ff      <= edge_in;
         cnt_ff       <= cnt_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff           <= line_in;
      wx_ff             <= wx_in;
      n_ff              <= n_in;
      slot_lo_ff        <= slot_lo_in;
      slot_hi_ff        <= slot_hi_in;
      rsp_span_valid_ff <= rsp_span_valid_in;
      rsp_lo_ff         <= rsp_lo_in;
      rsp_hi_ff         <= rsp_hi_in;
      rsp_color_ff      <= rsp_color_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.span_valid  = rsp_span_valid_ff;
   assign rsp_if.span_low    = rsp_lo_ff;
   assign rsp_if.span_high   = rsp_hi_ff;
   assign rsp_if.pixel_color = rsp_color_ff;
   assign rsp_if.last_result = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_walk_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !walk_res.busy)
      else $error("edge walker busy while sequencer idle");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      walk_res.done |-> state_ff == ST_WAIT)
      else $error("edge walk finished outside wait state");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_span_valid_ff |-> rsp_last_ff)
      else $error("empty result not marked last");

   a_fill_one_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && cfg.fill |-> cnt_ff <= CNT_BITS'(1))
      else $error("fill mode holds more than one span");
`endif

endmodule
